/* hw/rtl/known_bits_ternary_alu_top_macros.svh */
// assertion macros for the known-bits alu top level
`ifndef KNOWN_BITS_TERNARY_ALU_TOP_MACROS_SVH
`define KNOWN_BITS_TERNARY_ALU_TOP_MACROS_SVH

// same-cycle implication, checked only out of reset
`define KBTA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked only out of reset
`define KBTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/kbta_pkg.sv */
// types, opcodes and helper functions of the known-bits alu
`timescale 1ns / 1ps

package kbta_pkg;

   typedef logic [3:0] opcode_type;

   localparam opcode_type OpMeet     = 4'd0;
   localparam opcode_type OpJoin     = 4'd1;
   localparam opcode_type OpOr       = 4'd2;
   localparam opcode_type OpAnd      = 4'd3;
   localparam opcode_type OpXor      = 4'd4;
   localparam opcode_type OpNot      = 4'd5;
   localparam opcode_type OpShl      = 4'd6;
   localparam opcode_type OpSar      = 4'd7;
   localparam opcode_type OpZext     = 4'd8;
   localparam opcode_type OpSext     = 4'd9;
   localparam opcode_type OpExtract  = 4'd10;
   localparam opcode_type OpInsert   = 4'd11;
   localparam opcode_type OpBytePerm = 4'd12;
   localparam opcode_type OpShlByB   = 4'd13;
   localparam opcode_type OpSarByB   = 4'd14;

   localparam logic [63:0] AllOnes  = {64{1'b1}};
   localparam logic [63:0] AllZeros = {64{1'b0}};

   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] a_zero_mask;
      logic [63:0] a_one_mask;
      logic [63:0] b_zero_mask;
      logic [63:0] b_one_mask;
      logic [6:0]  shift_amount;
      logic [6:0]  field_width;
      logic [7:0]  perm_select;
   } req_type;

   typedef struct packed {
      logic [63:0] r_zero_mask;
      logic [63:0] r_one_mask;
      logic [6:0]  lead_known_zeros;
      logic [6:0]  lead_known_ones;
      logic [6:0]  trail_known_zeros;
      logic [6:0]  trail_known_ones;
      logic        is_constant;
      logic        is_equal;
      logic        strictly_contains;
   } rsp_type;

   // decoded word after the first stage
   typedef struct packed {
      opcode_type  opcode;
      logic [63:0] a_z;
      logic [63:0] a_o;
      logic [63:0] b_z;
      logic [63:0] b_o;
      logic        a_top;
      logic        b_top;
      logic        b_known;
      logic [5:0]  amt;
      logic        sat;
      logic [63:0] field_low;
      logic        fw_zero;
      logic        fw_big;
      logic        range_bad;
      logic [5:0]  sext_idx;
      logic [63:0] src_z;
      logic [63:0] src_o;
      logic [7:0]  perm_select;
      logic        is_constant;
      logic        is_equal;
      logic        strictly_contains;
   } dec_type;

   // result masks plus what the query stage still needs
   typedef struct packed {
      logic [63:0] r_z;
      logic [63:0] r_o;
      logic [63:0] a_z;
      logic [63:0] a_o;
      logic        a_top;
      logic        is_constant;
      logic        is_equal;
      logic        strictly_contains;
   } ex_type;

   function automatic logic [63:0] sar_fn(input logic [63:0] x, input logic [5:0] n,
                                          input logic sat);
      logic [63:0] r;
      if (sat) begin
         r = {64{x[63]}};
      end else begin
         r = 64'($signed(x) >>> n);
      end
      return r;
   endfunction

   function automatic logic [63:0] perm_fn(input logic [63:0] x, input logic [7:0] sel);
      logic [31:0] lo;
      lo = '0;
      for (int i = 0; i < 4; i++) begin
         case (sel[2*i +: 2])
            2'd0:    lo[8*i +: 8] = x[7:0];
            2'd1:    lo[8*i +: 8] = x[15:8];
            2'd2:    lo[8*i +: 8] = x[23:16];
            default: lo[8*i +: 8] = x[31:24];
         endcase
      end
      return {{32{lo[31]}}, lo};
   endfunction

   // leading run of ones, six halving steps
   function automatic logic [6:0] lead_ones_fn(input logic [63:0] x);
      logic [63:0] v;
      logic [6:0]  n;
      v = x;
      n = '0;
      if (&v) begin
         n = 7'd64;
      end else begin
         if (&v[63:32]) begin n = n + 7'd32; v = v << 32; end
         if (&v[63:48]) begin n = n + 7'd16; v = v << 16; end
         if (&v[63:56]) begin n = n + 7'd8;  v = v << 8;  end
         if (&v[63:60]) begin n = n + 7'd4;  v = v << 4;  end
         if (&v[63:62]) begin n = n + 7'd2;  v = v << 2;  end
         if (v[63]) begin n = n + 7'd1; end
      end
      return n;
   endfunction

   function automatic logic [6:0] trail_ones_fn(input logic [63:0] x);
      logic [63:0] rev;
      for (int i = 0; i < 64; i++) begin
         rev[i] = x[63-i];
      end
      return lead_ones_fn(rev);
   endfunction

endpackage

/* hw/rtl/kbta_decode.sv */
// first stage: top detection, shift count and field mask setup, queries on a and b
`timescale 1ns / 1ps

module kbta_decode import kbta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output dec_type out_word
);

   dec_type     dec_in, dec_ff;
   logic        valid_in, valid_ff;
   logic [63:0] va, vb;
   logic [7:0]  range_sum;

   assign va        = in_word.a_zero_mask ^ in_word.a_one_mask;
   assign vb        = in_word.b_zero_mask ^ in_word.b_one_mask;
   assign range_sum = {1'b0, in_word.shift_amount} + {1'b0, in_word.field_width};

   always_comb begin
      dec_in             = '0;
      dec_in.opcode      = in_word.opcode;
      dec_in.a_z         = in_word.a_zero_mask;
      dec_in.a_o         = in_word.a_one_mask;
      dec_in.b_z         = in_word.b_zero_mask;
      dec_in.b_o         = in_word.b_one_mask;
      dec_in.a_top       = (&in_word.a_zero_mask) & (&in_word.a_one_mask);
      dec_in.b_top       = (&in_word.b_zero_mask) & (&in_word.b_one_mask);
      dec_in.b_known     = &vb;
      dec_in.perm_select = in_word.perm_select;

      // shift by b takes its count from the one mask of b
      if (in_word.opcode == OpShlByB || in_word.opcode == OpSarByB) begin
         dec_in.amt = in_word.b_one_mask[5:0];
         dec_in.sat = |in_word.b_one_mask[63:6];
      end else begin
         dec_in.amt = in_word.shift_amount[5:0];
         dec_in.sat = in_word.shift_amount[6];
      end

      dec_in.field_low = in_word.field_width[6] ? AllOnes
                                                : ~(AllOnes << in_word.field_width[5:0]);
      dec_in.fw_zero   = (in_word.field_width == 7'd0);
      dec_in.fw_big    = (in_word.field_width > 7'd64);
      dec_in.range_bad = (range_sum > 8'd64);
      dec_in.sext_idx  = in_word.field_width[5:0] - 6'd1;

      // insert shifts b, masked to the field unless b is top; everything else shifts a
      if (in_word.opcode == OpInsert && !dec_in.b_top) begin
         dec_in.src_z = in_word.b_zero_mask | ~dec_in.field_low;
         dec_in.src_o = in_word.b_one_mask & dec_in.field_low;
      end else if (in_word.opcode == OpInsert) begin
         dec_in.src_z = in_word.b_zero_mask;
         dec_in.src_o = in_word.b_one_mask;
      end else begin
         dec_in.src_z = in_word.a_zero_mask;
         dec_in.src_o = in_word.a_one_mask;
      end

      dec_in.is_constant = !dec_in.a_top && (&va);
      dec_in.is_equal    = (in_word.a_zero_mask == in_word.b_zero_mask) &&
                           (in_word.a_one_mask == in_word.b_one_mask);
      if (dec_in.a_top) begin
         dec_in.strictly_contains = 1'b0;
      end else if (dec_in.b_top) begin
         dec_in.strictly_contains = 1'b1;
      end else begin
         dec_in.strictly_contains = ((va & vb) == va) && !dec_in.is_equal;
      end
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         dec_ff <= dec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = dec_ff;

endmodule

/* hw/rtl/kbta_exec.sv */
// second stage: shifters, permute, extends and the per-opcode result select
`timescale 1ns / 1ps

module kbta_exec import kbta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  dec_type in_word,
   output logic    out_valid,
   input  logic    out_ready,
   output ex_type  out_word
);

   ex_type      ex_in, ex_ff;
   logic        valid_in, valid_ff;
   logic [63:0] shl_z, shl_o, sar_z, sar_o;
   logic [63:0] sext_z, sext_o, low;
   logic        fill_z, fill_o;

   assign low = in_word.field_low;

   // zero mask fills ones from the right, one mask fills zeros
   assign shl_z = in_word.sat ? AllOnes  : ~((~in_word.src_z) << in_word.amt);
   assign shl_o = in_word.sat ? AllZeros : (in_word.src_o << in_word.amt);
   assign sar_z = sar_fn(in_word.a_z, in_word.amt, in_word.sat);
   assign sar_o = sar_fn(in_word.a_o, in_word.amt, in_word.sat);

   assign fill_z = in_word.a_z[in_word.sext_idx];
   assign fill_o = in_word.a_o[in_word.sext_idx];
   assign sext_z = (in_word.a_z & low) | ({64{fill_z}} & ~low);
   assign sext_o = (in_word.a_o & low) | ({64{fill_o}} & ~low);

   always_comb begin
      ex_in                   = '0;
      ex_in.a_z               = in_word.a_z;
      ex_in.a_o               = in_word.a_o;
      ex_in.a_top             = in_word.a_top;
      ex_in.is_constant       = in_word.is_constant;
      ex_in.is_equal          = in_word.is_equal;
      ex_in.strictly_contains = in_word.strictly_contains;
      ex_in.r_z               = AllZeros;
      ex_in.r_o               = AllZeros;

      unique case (in_word.opcode)
         OpMeet: begin
            if (in_word.b_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else if (in_word.a_top) begin
               ex_in.r_z = in_word.b_z; ex_in.r_o = in_word.b_o;
            end else begin
               ex_in.r_z = in_word.a_z & in_word.b_z;
               ex_in.r_o = in_word.a_o & in_word.b_o;
            end
         end
         OpJoin: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else if (in_word.b_top) begin
               ex_in.r_z = in_word.b_z; ex_in.r_o = in_word.b_o;
            end else begin
               ex_in.r_z = in_word.a_z | in_word.b_z;
               ex_in.r_o = in_word.a_o | in_word.b_o;
            end
         end
         OpOr: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.b_z; ex_in.r_o = in_word.b_o;
            end else if (in_word.b_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = in_word.a_z & in_word.b_z;
               ex_in.r_o = in_word.a_o | in_word.b_o;
            end
         end
         OpAnd: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else if (in_word.b_top) begin
               ex_in.r_z = in_word.b_z; ex_in.r_o = in_word.b_o;
            end else begin
               ex_in.r_z = in_word.a_z | in_word.b_z;
               ex_in.r_o = in_word.a_o & in_word.b_o;
            end
         end
         OpXor: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.b_z; ex_in.r_o = in_word.b_o;
            end else if (in_word.b_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = (in_word.a_z & in_word.b_z) | (in_word.a_o & in_word.b_o);
               ex_in.r_o = (in_word.a_z & in_word.b_o) | (in_word.a_o & in_word.b_z);
            end
         end
         OpNot: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = in_word.a_o; ex_in.r_o = in_word.a_z;
            end
         end
         OpShl: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = shl_z; ex_in.r_o = shl_o;
            end
         end
         OpSar: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = sar_z; ex_in.r_o = sar_o;
            end
         end
         OpZext: begin
            if (in_word.fw_big) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = (in_word.a_z & low) | ~low;
               ex_in.r_o = in_word.a_o & low;
            end
         end
         OpSext: begin
            if (in_word.fw_big) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else if (in_word.fw_zero) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else begin
               ex_in.r_z = sext_z; ex_in.r_o = sext_o;
            end
         end
         OpExtract: begin
            if (in_word.range_bad) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else if ((&sar_z) && (&sar_o)) begin
               // a shifted value that reads as top, a top a included, stays top
               ex_in.r_z = AllOnes; ex_in.r_o = AllOnes;
            end else begin
               ex_in.r_z = sar_z | ~low;
               ex_in.r_o = sar_o & low;
            end
         end
         OpInsert: begin
            if (in_word.range_bad) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else if (in_word.b_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else if (in_word.a_top) begin
               ex_in.r_z = shl_z; ex_in.r_o = shl_o;
            end else begin
               ex_in.r_z = shl_z & in_word.a_z;
               ex_in.r_o = shl_o | in_word.a_o;
            end
         end
         OpBytePerm: begin
            if (in_word.a_top) begin
               ex_in.r_z = in_word.a_z; ex_in.r_o = in_word.a_o;
            end else begin
               ex_in.r_z = perm_fn(in_word.a_z, in_word.perm_select);
               ex_in.r_o = perm_fn(in_word.a_o, in_word.perm_select);
            end
         end
         OpShlByB: begin
            if (in_word.a_top || in_word.b_top) begin
               ex_in.r_z = AllOnes; ex_in.r_o = AllOnes;
            end else if (!in_word.b_known || in_word.b_o[63]) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else begin
               ex_in.r_z = shl_z; ex_in.r_o = shl_o;
            end
         end
         OpSarByB: begin
            if (in_word.a_top || in_word.b_top) begin
               ex_in.r_z = AllOnes; ex_in.r_o = AllOnes;
            end else if (!in_word.b_known) begin
               ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
            end else begin
               ex_in.r_z = sar_z; ex_in.r_o = sar_o;
            end
         end
         default: begin
            ex_in.r_z = AllZeros; ex_in.r_o = AllZeros;
         end
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         ex_ff <= ex_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = ex_ff;

endmodule

/* hw/rtl/known_bits_ternary_alu_top.sv */
// pipeline: an accepted req word passes the decode, execute and query/output registers to rsp_valid
// throughput: one word per cycle while rsp_ready does not stall; each stage has its own valid bit, so bubbles collapse
// and a stall on rsp_ready holds every word in place without loss or repeat
// reset: synchronous, active high; clears only the stage valid bits, no data is cleared
// the 64-bit shifters in execute and the leading/trailing run counters set the stage depth
`timescale 1ns / 1ps

module known_bits_ternary_alu_top import kbta_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

`include "known_bits_ternary_alu_top_macros.svh"

   // stage 1 -> stage 2
   logic    dec_valid, dec_ready;
   dec_type dec_word;

   // stage 2 -> stage 3
   logic    ex_valid, ex_ready;
   ex_type  ex_word;

   // stage 3: output register
   rsp_type rsp_in, rsp_ff;
   logic    rsp_valid_in, rsp_valid_ff;

   kbta_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_data),
      .out_valid (dec_valid),
      .out_ready (dec_ready),
      .out_word  (dec_word)
   );

   kbta_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_word   (dec_word),
      .out_valid (ex_valid),
      .out_ready (ex_ready),
      .out_word  (ex_word)
   );

   // run counts of a; a leading run of ones in the zero mask is a run of proved zeros
   always_comb begin
      rsp_in                   = '0;
      rsp_in.r_zero_mask       = ex_word.r_z;
      rsp_in.r_one_mask        = ex_word.r_o;
      rsp_in.is_constant       = ex_word.is_constant;
      rsp_in.is_equal          = ex_word.is_equal;
      rsp_in.strictly_contains = ex_word.strictly_contains;
      if (!ex_word.a_top) begin
         rsp_in.lead_known_zeros  = lead_ones_fn(ex_word.a_z);
         rsp_in.lead_known_ones   = lead_ones_fn(ex_word.a_o);
         rsp_in.trail_known_zeros = trail_ones_fn(ex_word.a_z);
         rsp_in.trail_known_ones  = trail_ones_fn(ex_word.a_o);
      end
   end

   // output register frees up as soon as the held word is taken
   assign ex_ready     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = ex_ready ? ex_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_valid && ex_ready) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // an accepted word always lands in the decode stage
   `KBTA_ASSERT_NEXT(a_req_lands, clock, reset, req_valid && req_ready, dec_valid, "accepted word lost at decode")

   // equal operands can never strictly contain one another
   `KBTA_ASSERT_NOW(a_eq_excl, clock, reset, rsp_valid, !(rsp_data.is_equal && rsp_data.strictly_contains), "equal and strictly contains both set")

   // a constant has a leading run of exactly one kind
   `KBTA_ASSERT_NOW(a_const_lead, clock, reset, rsp_valid && rsp_data.is_constant, (rsp_data.lead_known_zeros == 7'd0) != (rsp_data.lead_known_ones == 7'd0), "constant with bad leading runs")

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the known-bits alu: directed table, then random words
`timescale 1ns / 1ps

module tb_top;
   import kbta_pkg::*;

   // opcode 15 has no package name; the alu must answer it with bottom
   localparam opcode_type OpUnused = 4'd15;

   localparam int HoldCycles    = 60;    // long receiver hold-off for the pressure phase
   localparam int WatchdogLimit = 2000;  // cycles without any handshake before giving up
   localparam int TailCycles    = 10;    // leave room for stray results after the drain
   localparam int PrintLimit    = 30;    // mismatch lines printed before going quiet

   // fixed operand patterns for the directed rows; each zero/one pair is disjoint
   localparam logic [63:0] PatZ   = 64'h00FF_F000_0F0F_3C00;
   localparam logic [63:0] PatO   = 64'hFF00_0F00_F0F0_C003;
   localparam logic [63:0] QatZ   = 64'h0F0F_0F0F_0000_FFFF;
   localparam logic [63:0] QatO   = 64'hF0F0_0000_FF00_0000;
   localparam logic [63:0] NegBit = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [63:0] z;
      logic [63:0] o;
   } known_pair_t;

   localparam known_pair_t PairTop    = '{AllOnes, AllOnes};
   localparam known_pair_t PairBottom = '{AllZeros, AllZeros};

   // one row of the directed part; want is only used where typed is set
   typedef struct {
      req_type word;
      bit      typed;
      rsp_type want;
   } stim_row_t;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // expected result of the word on req_data, moves with it
   rsp_type result_for_word = '0;

   rsp_type   pending_results[$];
   stim_row_t directed_rows[$];

   int fail_count      = 0;
   int words_accepted  = 0;
   int results_checked = 0;
   int idle_cycles     = 0;
   int holds_done      = 0;
   bit opcode_hits [16];
   bit no_idle         = 1'b0;
   bit hold_requested  = 1'b0;

   known_bits_ternary_alu_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // known-bits predictor
   // ---------------------------------------------------------------------------------

   function automatic bit is_top(input known_pair_t v);
      return (v.z == AllOnes) && (v.o == AllOnes);
   endfunction

   // ones in the low w bits, saturating at the full word
   function automatic logic [63:0] ones_below(input logic [63:0] w);
      return (w >= 64) ? AllOnes : ((64'd1 << w) - 64'd1);
   endfunction

   function automatic logic [63:0] shift_right_signed(input logic [63:0] x,
                                                      input logic [63:0] n);
      if (n >= 64) return {64{x[63]}};
      return 64'($signed(x) >>> n);
   endfunction

   function automatic known_pair_t pair_or(input known_pair_t a, input known_pair_t b);
      if (is_top(a)) return b;
      if (is_top(b)) return a;
      return '{a.z & b.z, a.o | b.o};
   endfunction

   function automatic known_pair_t pair_and(input known_pair_t a, input known_pair_t b);
      if (is_top(a)) return a;
      if (is_top(b)) return b;
      return '{a.z | b.z, a.o & b.o};
   endfunction

   // vacated low bits become proved zero
   function automatic known_pair_t pair_shl(input known_pair_t a, input logic [63:0] n);
      if (is_top(a)) return a;
      if (n >= 64) return '{AllOnes, AllZeros};
      return '{(a.z << n) | ones_below(n), a.o << n};
   endfunction

   function automatic known_pair_t pair_sar(input known_pair_t a, input logic [63:0] n);
      if (is_top(a)) return a;
      return '{shift_right_signed(a.z, n), shift_right_signed(a.o, n)};
   endfunction

   // copy bit w-1 into every bit above it; zero width clears the mask
   function automatic logic [63:0] sign_fill(input logic [63:0] x, input logic [6:0] w);
      logic [63:0] keep;
      keep = ones_below(64'(w));
      if (w == 0) return AllZeros;
      if (w >= 64) return x;
      x = x & keep;
      if (x[w - 1]) x = x | ~keep;
      return x;
   endfunction

   function automatic logic [63:0] byte_shuffle(input logic [63:0] x, input logic [7:0] sel);
      logic [63:0] r;
      r = AllZeros;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = x[8*sel[2*i +: 2] +: 8];
      end
      if (r[31]) r[63:32] = '1;
      return r;
   endfunction

   function automatic logic [6:0] run_from_top(input logic [63:0] x);
      logic [6:0] n;
      n = 0;
      while (n < 64 && x[63 - n]) n++;
      return n;
   endfunction

   function automatic logic [6:0] run_from_bottom(input logic [63:0] x);
      logic [6:0] n;
      n = 0;
      while (n < 64 && x[n]) n++;
      return n;
   endfunction

   function automatic rsp_type predict_known_bits(input req_type w);
      known_pair_t a, b, r, field;
      logic [63:0] sh, fw, va, vb;
      bit          a_top, b_top, same;
      rsp_type     p;
      a     = '{w.a_zero_mask, w.a_one_mask};
      b     = '{w.b_zero_mask, w.b_one_mask};
      sh    = 64'(w.shift_amount);
      fw    = 64'(w.field_width);
      a_top = is_top(a);
      b_top = is_top(b);
      field = '{~ones_below(fw), ones_below(fw)};
      r     = PairBottom;
      case (w.opcode)
         OpMeet: begin
            if (b_top) r = a;
            else if (a_top) r = b;
            else r = '{a.z & b.z, a.o & b.o};
         end
         OpJoin: begin
            if (a_top) r = a;
            else if (b_top) r = b;
            else r = '{a.z | b.z, a.o | b.o};
         end
         OpOr:  r = pair_or(a, b);
         OpAnd: r = pair_and(a, b);
         OpXor: begin
            if (a_top) r = b;
            else if (b_top) r = a;
            else r = '{(a.z & b.z) | (a.o & b.o), (a.z & b.o) | (a.o & b.z)};
         end
         OpNot: r = a_top ? a : '{a.o, a.z};
         OpShl: r = pair_shl(a, sh);
         OpSar: r = pair_sar(a, sh);
         OpZext: begin
            if (fw > 64) r = PairBottom;
            else if (a_top) r = a;
            else r = '{(a.z & field.o) | field.z, a.o & field.o};
         end
         OpSext: begin
            if (fw > 64) r = PairBottom;
            else if (a_top) r = a;
            else r = '{sign_fill(a.z, w.field_width), sign_fill(a.o, w.field_width)};
         end
         OpExtract: begin
            if (sh + fw > 64) r = PairBottom;
            else r = pair_and(pair_sar(a, sh), field);
         end
         OpInsert: begin
            if (sh + fw > 64) r = PairBottom;
            else r = pair_or(pair_shl(pair_and(b, field), sh), a);
         end
         OpBytePerm: begin
            if (a_top) r = a;
            else r = '{byte_shuffle(a.z, w.perm_select), byte_shuffle(a.o, w.perm_select)};
         end
         OpShlByB, OpSarByB: begin
            if (a_top || b_top) r = PairTop;
            else if ((b.z ^ b.o) != AllOnes) r = PairBottom;
            else if (w.opcode == OpShlByB) r = b.o[63] ? PairBottom : pair_shl(a, b.o);
            else r = pair_sar(a, b.o);
         end
         default: r = PairBottom;
      endcase

      va   = a.z ^ a.o;
      vb   = b.z ^ b.o;
      same = (a == b);
      p.r_zero_mask       = r.z;
      p.r_one_mask        = r.o;
      p.lead_known_zeros  = a_top ? 7'd0 : run_from_top(a.z);
      p.lead_known_ones   = a_top ? 7'd0 : run_from_top(a.o);
      p.trail_known_zeros = a_top ? 7'd0 : run_from_bottom(a.z);
      p.trail_known_ones  = a_top ? 7'd0 : run_from_bottom(a.o);
      p.is_constant       = !a_top && (va == AllOnes);
      p.is_equal          = same;
      if (a_top) p.strictly_contains = 1'b0;
      else if (b_top) p.strictly_contains = 1'b1;
      else p.strictly_contains = ((va & vb) == va) && !same;
      return p;
   endfunction

   // ---------------------------------------------------------------------------------
   // stimulus builders
   // ---------------------------------------------------------------------------------

   function automatic req_type make_word(input opcode_type op,
                                         input logic [63:0] az, input logic [63:0] ao,
                                         input logic [63:0] bz, input logic [63:0] bo,
                                         input logic [6:0] sh, input logic [6:0] fw,
                                         input logic [7:0] sel);
      req_type w;
      w.opcode       = op;
      w.a_zero_mask  = az;
      w.a_one_mask   = ao;
      w.b_zero_mask  = bz;
      w.b_one_mask   = bo;
      w.shift_amount = sh;
      w.field_width  = fw;
      w.perm_select  = sel;
      return w;
   endfunction

   function automatic rsp_type make_rsp(input logic [63:0] rz, input logic [63:0] ro,
                                        input logic [6:0] lkz, input logic [6:0] lko,
                                        input logic [6:0] tkz, input logic [6:0] tko,
                                        input logic cst, input logic eq, input logic sc);
      rsp_type p;
      p.r_zero_mask       = rz;
      p.r_one_mask        = ro;
      p.lead_known_zeros  = lkz;
      p.lead_known_ones   = lko;
      p.trail_known_zeros = tkz;
      p.trail_known_ones  = tko;
      p.is_constant       = cst;
      p.is_equal          = eq;
      p.strictly_contains = sc;
      return p;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // mix of top, bottom, constants, consistent partial values, known runs at either
   // end (to move the leading/trailing counts) and contradictory masks
   function automatic known_pair_t random_known_value();
      int          kind;
      logic [63:0] known, val, hi, lo;
      kind  = $urandom_range(0, 99);
      known = rand64();
      val   = rand64();
      hi    = ~(AllOnes >> $urandom_range(0, 64));
      lo    = ~(AllOnes << $urandom_range(0, 64));
      if (kind < 8) return PairTop;
      if (kind < 13) return PairBottom;
      if (kind < 40) return '{~val, val};
      if (kind < 70) return '{known & ~val, known & val};
      if (kind < 85) begin
         if ($urandom_range(0, 1)) return '{hi, lo & ~hi};
         return '{lo, hi & ~lo};
      end
      return '{known, val};
   endfunction

   function automatic req_type random_word();
      req_type     w;
      known_pair_t a, b;
      logic [63:0] more, bits;
      w.opcode = ($urandom_range(0, 39) == 0) ? OpUnused : opcode_type'($urandom_range(0, 14));
      a = random_known_value();
      b = random_known_value();
      // equal operands, or b knowing more than a, so the containment query fires
      case ($urandom_range(0, 9))
         0: b = a;
         1: begin
            more = rand64() & ~(a.z | a.o);
            bits = rand64();
            b    = '{a.z | (more & ~bits), a.o | (more & bits)};
         end
         default: ;
      endcase
      // shifts by b mostly get a fully known count, sometimes a negative one
      if ((w.opcode == OpShlByB || w.opcode == OpSarByB) && $urandom_range(0, 3) != 0) begin
         bits = ($urandom_range(0, 4) == 0) ? rand64() : 64'($urandom_range(0, 70));
         b    = '{~bits, bits};
      end
      if ($urandom_range(0, 7) == 0) w.shift_amount = 7'($urandom_range(0, 127));
      else w.shift_amount = 7'($urandom_range(0, 64));
      // extract and insert mostly keep the field inside the word
      if ($urandom_range(0, 7) == 0) begin
         w.field_width = 7'($urandom_range(0, 127));
      end else if ((w.opcode == OpExtract || w.opcode == OpInsert) && w.shift_amount <= 64) begin
         w.field_width = 7'($urandom_range(0, 64 - w.shift_amount));
      end else begin
         w.field_width = 7'($urandom_range(0, 64));
      end
      w.perm_select = 8'($urandom_range(0, 255));
      w.a_zero_mask = a.z;
      w.a_one_mask  = a.o;
      w.b_zero_mask = b.z;
      w.b_one_mask  = b.o;
      return w;
   endfunction

   // ---------------------------------------------------------------------------------
   // checking
   // ---------------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      if (fail_count <= PrintLimit) begin
         $display("%0t ns: result %0d %s: got %h, expected %h",
                  $time, results_checked, what, got, want);
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      check_field("r_zero_mask", got.r_zero_mask, want.r_zero_mask);
      check_field("r_one_mask", got.r_one_mask, want.r_one_mask);
      check_field("lead_known_zeros", 64'(got.lead_known_zeros), 64'(want.lead_known_zeros));
      check_field("lead_known_ones", 64'(got.lead_known_ones), 64'(want.lead_known_ones));
      check_field("trail_known_zeros", 64'(got.trail_known_zeros),
                  64'(want.trail_known_zeros));
      check_field("trail_known_ones", 64'(got.trail_known_ones), 64'(want.trail_known_ones));
      check_field("is_constant", 64'(got.is_constant), 64'(want.is_constant));
      check_field("is_equal", 64'(got.is_equal), 64'(want.is_equal));
      check_field("strictly_contains", 64'(got.strictly_contains),
                  64'(want.strictly_contains));
   endtask

   // all sampling happens here, on pre-edge values; the expectation travels with the
   // word in result_for_word, so both are taken from the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            pending_results.push_back(result_for_word);
            words_accepted++;
            opcode_hits[req_data.opcode] = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("arrived with nothing expected", rsp_data.r_zero_mask, '0);
            end else begin
               check_result(rsp_data, pending_results.pop_front());
            end
            results_checked++;
         end
         // watchdog on any handshake, either side
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
               $display("watchdog: no handshake for %0d cycles", idle_cycles);
               $display("simulation failed");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------------------------

   // a random gap with valid low, then the word is offered until accepted; with no
   // gap valid stays high straight into the next word
   task automatic send_word(input req_type word, input rsp_type want);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data        <= word;
      result_for_word <= want;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   task automatic send_random(input int count);
      req_type w;
      for (int i = 0; i < count; i++) begin
         w = random_word();
         send_word(w, predict_known_bits(w));
      end
   endtask

   // drop valid and hold back until every outstanding result is in
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // ---------------------------------------------------------------------------------
   // receiver side: random stall before each word, or one long hold-off on request
   // ---------------------------------------------------------------------------------

   initial begin
      int stall;
      wait (!reset);
      forever begin
         if (hold_requested) begin
            stall          = HoldCycles;
            hold_requested = 1'b0;
            holds_done++;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 9);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      int      op_kinds;
      rsp_type want;

      // typed rows: results that follow directly from the operation's rules
      // meet of two bottoms right after reset
      directed_rows.push_back('{make_word(OpMeet, AllZeros, AllZeros, AllZeros, AllZeros,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 0, 0, 0, 0, 0, 1, 0)});
      // join with a top passes top through
      directed_rows.push_back('{make_word(OpJoin, AllOnes, AllOnes, AllZeros, AllZeros,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllOnes, AllOnes, 0, 0, 0, 0, 0, 0, 0)});
      // shift left by 64 saturates to constant zero
      directed_rows.push_back('{make_word(OpShl, AllOnes, AllZeros, AllZeros, AllZeros,
                                          7'd64, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllOnes, AllZeros, 64, 0, 64, 0, 1, 0, 0)});
      // arithmetic right by the largest count keeps all ones, b equal to a
      directed_rows.push_back('{make_word(OpSar, AllZeros, AllOnes, AllZeros, AllOnes,
                                          7'd127, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllOnes, 0, 64, 0, 64, 1, 1, 0)});
      // zero-extend wider than the word gives bottom even for top
      directed_rows.push_back('{make_word(OpZext, AllOnes, AllOnes, AllZeros, AllZeros,
                                          7'd0, 7'd65, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 0, 0, 0, 0, 0, 0, 0)});
      // sign-extend from zero width gives bottom; b top is strictly contained
      directed_rows.push_back('{make_word(OpSext, AllOnes, AllZeros, AllOnes, AllOnes,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 64, 0, 64, 0, 1, 0, 1)});
      // extract field running past bit 63
      directed_rows.push_back('{make_word(OpExtract, AllZeros, AllZeros, AllZeros, AllZeros,
                                          7'd60, 7'd5, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 0, 0, 0, 0, 0, 1, 0)});
      // insert field running past bit 63
      directed_rows.push_back('{make_word(OpInsert, AllOnes, AllZeros, AllZeros, AllZeros,
                                          7'd64, 7'd1, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 64, 0, 64, 0, 1, 0, 0)});
      // unused opcode
      directed_rows.push_back('{make_word(OpUnused, AllZeros, AllZeros, AllZeros, AllZeros,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 0, 0, 0, 0, 0, 1, 0)});
      // shift left by a negative known b
      directed_rows.push_back('{make_word(OpShlByB, AllOnes, AllZeros, ~NegBit, NegBit,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllZeros, 64, 0, 64, 0, 1, 0, 1)});
      // arithmetic right by a negative known b saturates
      directed_rows.push_back('{make_word(OpSarByB, AllZeros, AllOnes, ~NegBit, NegBit,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllZeros, AllOnes, 0, 64, 0, 64, 1, 0, 1)});
      // shift by a top b gives top
      directed_rows.push_back('{make_word(OpSarByB, AllZeros, AllZeros, AllOnes, AllOnes,
                                          7'd0, 7'd0, 8'd0), 1'b1,
                                make_rsp(AllOnes, AllOnes, 0, 0, 0, 0, 0, 0, 1)});

      // predicted rows: every operation but join, mostly on partly known operands
      directed_rows.push_back('{make_word(OpMeet, PatZ, PatO, QatZ, QatO, 7'd0, 7'd0, 8'd0),
                                1'b0, '0});
      directed_rows.push_back('{make_word(OpOr, PatZ, PatO, AllOnes, AllOnes, 7'd0, 7'd0,
                                          8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpAnd, PatZ, PatO, QatZ, QatO, 7'd0, 7'd0, 8'd0),
                                1'b0, '0});
      directed_rows.push_back('{make_word(OpXor, AllOnes, AllOnes, PatZ, PatO, 7'd0, 7'd0,
                                          8'd0), 1'b0, '0});
      // contradictory a: some bits claimed both zero and one
      directed_rows.push_back('{make_word(OpNot, QatZ, PatO | QatZ, QatZ, QatO, 7'd0, 7'd0,
                                          8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpShl, PatZ, PatO, QatZ, QatO, 7'd1, 7'd0, 8'd0),
                                1'b0, '0});
      directed_rows.push_back('{make_word(OpSar, PatZ, PatO, QatZ, QatO, 7'd63, 7'd0, 8'd0),
                                1'b0, '0});
      directed_rows.push_back('{make_word(OpZext, PatZ, PatO, QatZ, QatO, 7'd0, 7'd64,
                                          8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpSext, PatZ, PatO, QatZ, QatO, 7'd0, 7'd1, 8'd0),
                                1'b0, '0});
      directed_rows.push_back('{make_word(OpExtract, PatZ, PatO, QatZ, QatO, 7'd8, 7'd16,
                                          8'd0), 1'b0, '0});
      // zero-width field out of a top
      directed_rows.push_back('{make_word(OpExtract, AllOnes, AllOnes, QatZ, QatO, 7'd3,
                                          7'd0, 8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpInsert, PatZ, PatO, QatZ, QatO, 7'd56, 7'd8,
                                          8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpBytePerm, PatZ, PatO, QatZ, QatO, 7'd0, 7'd0,
                                          8'h1B), 1'b0, '0});
      directed_rows.push_back('{make_word(OpShlByB, PatZ, PatO, ~64'd5, 64'd5, 7'd0, 7'd0,
                                          8'd0), 1'b0, '0});
      directed_rows.push_back('{make_word(OpSarByB, PatZ, PatO, ~64'd63, 64'd63, 7'd0,
                                          7'd0, 8'd0), 1'b0, '0});

      // reset is synchronous and released at an edge
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         want = directed_rows[i].typed ? directed_rows[i].want
                                       : predict_known_bits(directed_rows[i].word);
         send_word(directed_rows[i].word, want);
      end
      wait_until_drained();

      // random words with random gaps on both sides
      send_random(600);

      // pressure: receiver holds off while words keep coming, filling the pipe
      hold_requested = 1'b1;
      no_idle        = 1'b1;
      send_random(40);
      wait_until_drained();

      // back-to-back stretch, no idling on either side
      send_random(500);
      wait_until_drained();
      no_idle = 1'b0;

      send_random(560);
      wait_until_drained();
      repeat (TailCycles) @(posedge clock);

      op_kinds = 0;
      foreach (opcode_hits[i]) if (opcode_hits[i]) op_kinds++;
      $display("covered %0d words and %0d results over %0d of 16 opcodes",
               words_accepted, results_checked, op_kinds);
      $display("receiver hold-offs: %0d, field mismatches: %0d", holds_done, fail_count);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
